>>> rtl/core/shns_pkg.sv
// ----------------------------------------------------------------------------
// Spatial hash neighbour search package
// Shared constants, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package shns_pkg;

    // Default sizes of the stores and of the result buffer.
    localparam int SHNS_MAX_PARTICLES = 4096;
    localparam int SHNS_HASH_SIZE     = 4096;
    localparam int SHNS_MAX_NEIGHBORS = 64;

    // Hash multipliers for the x and y cell coordinates.
    localparam logic [31:0] HASH_MUL_X = 32'd92837111;
    localparam logic [31:0] HASH_MUL_Y = 32'd689287499;

    // Configuration reset values (origin -100.0 and -1.0 in Q16.16).
    localparam logic [31:0] ORIGIN_X_RST    = 32'hFF9C_0000;
    localparam logic [31:0] ORIGIN_Y_RST    = 32'hFFFF_0000;
    localparam logic [31:0] INV_SPACING_RST = 32'd1456355;
    localparam logic [62:0] RADIUS_SQ_RST   = 63'd8697309;

    // Item modes.
    localparam logic [1:0] MODE_FRAME  = 2'd0;
    localparam logic [1:0] MODE_INSERT = 2'd1;
    localparam logic [1:0] MODE_QUERY  = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_ORIGIN_X    = 2'd0;
    localparam logic [1:0] CFG_ORIGIN_Y    = 2'd1;
    localparam logic [1:0] CFG_INV_SPACING = 2'd2;
    localparam logic [1:0] CFG_RADIUS_SQ   = 2'd3;

    // Datapath operations, one per cycle.
    typedef enum logic [4:0] {
        OP_NONE, OP_CLEAR, OP_EPOCH, OP_LOAD, OP_GM, OP_GX, OP_GY, OP_GYC,
        OP_CELL, OP_HX, OP_HY, OP_HM, OP_RQ, OP_RH, OP_RC, OP_BRD, OP_IWR,
        OP_BCHK, OP_PRD, OP_DM, OP_DX, OP_DY, OP_CMP, OP_NEXTC, OP_ORD,
        OP_OUT, OP_EMPTY
    } op_t;

    // Controller states.
    typedef enum logic [4:0] {
        ST_CLEAR, ST_IDLE, ST_GM, ST_GX, ST_GY, ST_GYC, ST_CELL, ST_HX, ST_HY,
        ST_HM, ST_RQ, ST_RH, ST_RC, ST_BRD, ST_IWR, ST_BCHK, ST_PRD, ST_DM,
        ST_DX, ST_DY, ST_CMP, ST_NEXTC, ST_OSTART, ST_ORD, ST_OUT
    } state_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic clr_done;
        logic query;
        logic walk_more;
        logic last_cell;
        logic count_zero;
        logic out_last;
    } status_t;

endpackage

>>> rtl/core/spatial_hash_neighbor_search.sv
// ----------------------------------------------------------------------------
// Spatial hash neighbour search
// Hashed uniform grid of 2-D particles with lazily cleared buckets.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low; results come out
// one per strobe on result_valid and must be taken in that cycle. After reset
// the block clears its bucket store with busy high; configuration writes are
// taken at any time. Every cell, hash and distance product passes through the
// single shared 32 x 32 multiplier, and the bucket, particle and result
// memories have registered reads.
// ----------------------------------------------------------------------------
module spatial_hash_neighbor_search #(
    parameter int MAX_PARTICLES = shns_pkg::SHNS_MAX_PARTICLES,
    parameter int HASH_SIZE     = shns_pkg::SHNS_HASH_SIZE,
    parameter int MAX_NEIGHBORS = shns_pkg::SHNS_MAX_NEIGHBORS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  mode,
    input  logic [11:0] particle_index,
    input  logic [31:0] pos_x,
    input  logic [31:0] pos_y,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [62:0] cfg_data,
    output logic        result_valid,
    output logic [11:0] neighbor_index,
    output logic        found,
    output logic        last_result,
    output logic        overflow
);

    shns_pkg::cmd_t    cmd;
    shns_pkg::status_t status;

    // Sequencer.
    shns_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .mode   (mode),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    // Arithmetic, stores and result registers.
    shns_datapath #(
        .MAX_PARTICLES (MAX_PARTICLES),
        .HASH_SIZE     (HASH_SIZE),
        .MAX_NEIGHBORS (MAX_NEIGHBORS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .mode           (mode),
        .particle_index (particle_index),
        .pos_x          (pos_x),
        .pos_y          (pos_y),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .result_valid   (result_valid),
        .neighbor_index (neighbor_index),
        .found          (found),
        .last_result    (last_result),
        .overflow       (overflow)
    );

endmodule

>>> rtl/core/shns_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module shns_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write and registered read.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/core/shns_ctrl.sv
// ----------------------------------------------------------------------------
// Spatial hash neighbour search controller
// Sequences the datapath one operation per cycle for each transaction.
// ----------------------------------------------------------------------------
module shns_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [1:0]         mode,
    input  shns_pkg::status_t  status,
    output shns_pkg::cmd_t     cmd,
    output logic               busy
);

    shns_pkg::state_t state_reg;
    shns_pkg::state_t state_next;

    // State register; reset starts the bucket clearing pass.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= shns_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and the operation issued this cycle.
    always_comb
    begin
        state_next = state_reg;
        cmd.op     = shns_pkg::OP_NONE;
        unique case (state_reg)
            shns_pkg::ST_CLEAR:
            begin
                cmd.op = shns_pkg::OP_CLEAR;
                if (status.clr_done)
                begin
                    state_next = shns_pkg::ST_IDLE;
                end
            end
            shns_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    unique case (mode)
                        shns_pkg::MODE_FRAME:
                        begin
                            cmd.op = shns_pkg::OP_EPOCH;
                        end
                        shns_pkg::MODE_INSERT, shns_pkg::MODE_QUERY:
                        begin
                            cmd.op     = shns_pkg::OP_LOAD;
                            state_next = shns_pkg::ST_GM;
                        end
                        default:
                        begin
                            cmd.op = shns_pkg::OP_NONE;
                        end
                    endcase
                end
            end
            shns_pkg::ST_GM:
            begin
                cmd.op     = shns_pkg::OP_GM;
                state_next = shns_pkg::ST_GX;
            end
            shns_pkg::ST_GX:
            begin
                cmd.op     = shns_pkg::OP_GX;
                state_next = shns_pkg::ST_GY;
            end
            shns_pkg::ST_GY:
            begin
                cmd.op     = shns_pkg::OP_GY;
                state_next = shns_pkg::ST_GYC;
            end
            shns_pkg::ST_GYC:
            begin
                cmd.op     = shns_pkg::OP_GYC;
                state_next = shns_pkg::ST_CELL;
            end
            shns_pkg::ST_CELL:
            begin
                cmd.op     = shns_pkg::OP_CELL;
                state_next = shns_pkg::ST_HX;
            end
            shns_pkg::ST_HX:
            begin
                cmd.op     = shns_pkg::OP_HX;
                state_next = shns_pkg::ST_HY;
            end
            shns_pkg::ST_HY:
            begin
                cmd.op     = shns_pkg::OP_HY;
                state_next = shns_pkg::ST_HM;
            end
            shns_pkg::ST_HM:
            begin
                cmd.op     = shns_pkg::OP_HM;
                state_next = shns_pkg::ST_RQ;
            end
            shns_pkg::ST_RQ:
            begin
                cmd.op     = shns_pkg::OP_RQ;
                state_next = shns_pkg::ST_RH;
            end
            shns_pkg::ST_RH:
            begin
                cmd.op     = shns_pkg::OP_RH;
                state_next = shns_pkg::ST_RC;
            end
            shns_pkg::ST_RC:
            begin
                cmd.op     = shns_pkg::OP_RC;
                state_next = shns_pkg::ST_BRD;
            end
            shns_pkg::ST_BRD:
            begin
                cmd.op     = shns_pkg::OP_BRD;
                state_next = status.query ? shns_pkg::ST_BCHK : shns_pkg::ST_IWR;
            end
            shns_pkg::ST_IWR:
            begin
                cmd.op     = shns_pkg::OP_IWR;
                state_next = shns_pkg::ST_IDLE;
            end
            shns_pkg::ST_BCHK:
            begin
                cmd.op     = shns_pkg::OP_BCHK;
                state_next = shns_pkg::ST_PRD;
            end
            shns_pkg::ST_PRD:
            begin
                if (status.walk_more)
                begin
                    cmd.op     = shns_pkg::OP_PRD;
                    state_next = shns_pkg::ST_DM;
                end
                else
                begin
                    state_next = shns_pkg::ST_NEXTC;
                end
            end
            shns_pkg::ST_DM:
            begin
                cmd.op     = shns_pkg::OP_DM;
                state_next = shns_pkg::ST_DX;
            end
            shns_pkg::ST_DX:
            begin
                cmd.op     = shns_pkg::OP_DX;
                state_next = shns_pkg::ST_DY;
            end
            shns_pkg::ST_DY:
            begin
                cmd.op     = shns_pkg::OP_DY;
                state_next = shns_pkg::ST_CMP;
            end
            shns_pkg::ST_CMP:
            begin
                cmd.op     = shns_pkg::OP_CMP;
                state_next = shns_pkg::ST_PRD;
            end
            shns_pkg::ST_NEXTC:
            begin
                cmd.op     = shns_pkg::OP_NEXTC;
                state_next = status.last_cell ? shns_pkg::ST_OSTART : shns_pkg::ST_CELL;
            end
            shns_pkg::ST_OSTART:
            begin
                if (status.count_zero)
                begin
                    cmd.op     = shns_pkg::OP_EMPTY;
                    state_next = shns_pkg::ST_IDLE;
                end
                else
                begin
                    cmd.op     = shns_pkg::OP_ORD;
                    state_next = shns_pkg::ST_OUT;
                end
            end
            shns_pkg::ST_ORD:
            begin
                cmd.op     = shns_pkg::OP_ORD;
                state_next = shns_pkg::ST_OUT;
            end
            shns_pkg::ST_OUT:
            begin
                cmd.op     = shns_pkg::OP_OUT;
                state_next = status.out_last ? shns_pkg::ST_IDLE : shns_pkg::ST_ORD;
            end
            default:
            begin
                state_next = shns_pkg::ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != shns_pkg::ST_IDLE);

endmodule

>>> rtl/core/shns_datapath.sv
// ----------------------------------------------------------------------------
// Spatial hash neighbour search datapath
// Configuration, shared multiplier, hash, bucket and particle stores, result
// buffer and result registers.
// ----------------------------------------------------------------------------
module shns_datapath #(
    parameter int MAX_PARTICLES = shns_pkg::SHNS_MAX_PARTICLES,
    parameter int HASH_SIZE     = shns_pkg::SHNS_HASH_SIZE,
    parameter int MAX_NEIGHBORS = shns_pkg::SHNS_MAX_NEIGHBORS
) (
    input  logic               clk,
    input  logic               rst_n,
    input  shns_pkg::cmd_t     cmd,
    output shns_pkg::status_t  status,
    input  logic [1:0]         mode,
    input  logic [11:0]        particle_index,
    input  logic [31:0]        pos_x,
    input  logic [31:0]        pos_y,
    input  logic               cfg_write,
    input  logic [1:0]         cfg_index,
    input  logic [62:0]        cfg_data,
    output logic               result_valid,
    output logic [11:0]        neighbor_index,
    output logic               found,
    output logic               last_result,
    output logic               overflow
);

    localparam int IW  = $clog2(MAX_PARTICLES);
    localparam int HW  = $clog2(HASH_SIZE);
    localparam int CW  = $clog2(MAX_NEIGHBORS + 1);
    localparam int HAW = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;
    localparam int SW  = IW + 1;
    localparam int BW  = 33 + IW;
    localparam int PW  = 65 + IW;
    localparam logic [63:0] RECIP64     = 64'h1_0000_0000 / 64'(HASH_SIZE);
    localparam logic [31:0] RECIP       = RECIP64[31:0];
    localparam logic [31:0] HASH_SIZE32 = 32'(HASH_SIZE);
    localparam logic [31:0] MAXP32      = 32'(MAX_PARTICLES);

    // Signed difference: sign bit over 32-bit magnitude.
    function automatic logic [32:0] abs_diff(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] d;
        logic [32:0] n;
        d = {a[31], a} - {b[31], b};
        n = d[32] ? (33'd0 - d) : d;
        return {d[32], n[31:0]};
    endfunction

    // Floor of the Q32.32 cell product, saturated to the signed 32-bit range.
    function automatic logic [31:0] cell_of(input logic [63:0] p, input logic neg);
        logic [32:0] up;
        logic [32:0] m;
        logic [31:0] r;
        up = {1'b0, p[63:32]} + {32'd0, |p[31:0]};
        m  = 33'd0 - up;
        if (neg)
        begin
            r = (up > 33'h0_8000_0000) ? 32'h8000_0000 : m[31:0];
        end
        else
        begin
            r = p[63] ? 32'h7FFF_FFFF : p[63:32];
        end
        return r;
    endfunction

    shns_pkg::op_t op;

    // Configuration and control registers.
    logic [31:0]    origin_x_reg, origin_y_reg, inv_reg;
    logic [62:0]    rsq_reg;
    logic [31:0]    epoch_reg;
    logic [1:0]     mode_reg;
    logic [1:0]     nx_reg, ny_reg;
    logic           cur_valid_reg;
    logic [SW-1:0]  steps_reg;
    logic [CW-1:0]  count_reg, k_reg;
    logic           over_reg;
    logic [HW-1:0]  clr_reg;
    logic           res_valid_reg;

    // Payload registers.
    logic [11:0]    idx_reg;
    logic [31:0]    px_reg, py_reg;
    logic           signx_reg, signy_reg;
    logic [31:0]    magx_reg, magy_reg;
    logic [63:0]    prod_reg, dx2_reg;
    logic [31:0]    gx_reg, gy_reg, cx_reg, cy_reg, hx_reg;
    logic [HW-1:0]  hash_reg;
    logic [IW-1:0]  cur_id_reg;
    logic [11:0]    res_index_reg;
    logic           res_found_reg, res_last_reg, res_over_reg;

    // Combinational helpers.
    logic [31:0]    mul_a, mul_b;
    logic [63:0]    mul_p;
    logic [32:0]    org_dx, org_dy, st_dx, st_dy;
    logic [31:0]    hv, hmag, rem, rem_fix;
    logic [63:0]    dist_sum;
    logic           hit, live, idx_ok, count_full;
    logic [31:0]    idx_ext, hit_ext;
    logic [IW-1:0]  idx_addr;
    logic [CW-1:0]  k_plus;

    // Store ports.
    logic           bkt_we, bkt_re;
    logic [HW-1:0]  bkt_waddr;
    logic [BW-1:0]  bkt_wdata, bkt_rd;
    logic           part_we, part_re;
    logic [PW-1:0]  part_wdata, part_rd;
    logic           hits_we, hits_re;
    logic [IW-1:0]  hits_rd;
    logic [31:0]    bkt_epoch, st_x, st_y;
    logic           bkt_hvalid, st_lvalid;
    logic [IW-1:0]  bkt_head, st_next;

    assign op = cmd.op;

    // Field views of the store words.
    assign bkt_epoch  = bkt_rd[BW-1 -: 32];
    assign bkt_hvalid = bkt_rd[IW];
    assign bkt_head   = bkt_rd[IW-1:0];
    assign st_x       = part_rd[PW-1 -: 32];
    assign st_y       = part_rd[IW+32 : IW+1];
    assign st_lvalid  = part_rd[IW];
    assign st_next    = part_rd[IW-1:0];

    // Shared 32 x 32 multiplier operand selection.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (op)
            shns_pkg::OP_GX:
            begin
                mul_a = magx_reg;
                mul_b = inv_reg;
            end
            shns_pkg::OP_GY:
            begin
                mul_a = magy_reg;
                mul_b = inv_reg;
            end
            shns_pkg::OP_HX:
            begin
                mul_a = cx_reg;
                mul_b = shns_pkg::HASH_MUL_X;
            end
            shns_pkg::OP_HY:
            begin
                mul_a = cy_reg;
                mul_b = shns_pkg::HASH_MUL_Y;
            end
            shns_pkg::OP_RQ:
            begin
                mul_a = magx_reg;
                mul_b = RECIP;
            end
            shns_pkg::OP_RH:
            begin
                mul_a = prod_reg[63:32];
                mul_b = HASH_SIZE32;
            end
            shns_pkg::OP_DX:
            begin
                mul_a = magx_reg;
                mul_b = magx_reg;
            end
            shns_pkg::OP_DY:
            begin
                mul_a = magy_reg;
                mul_b = magy_reg;
            end
            default:
            begin
                mul_a = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // Differences against the origin and against the query position.
    assign org_dx = abs_diff(px_reg, origin_x_reg);
    assign org_dy = abs_diff(py_reg, origin_y_reg);
    assign st_dx  = abs_diff(st_x, px_reg);
    assign st_dy  = abs_diff(st_y, py_reg);

    // Hash magnitude and reduction by the table size with one correction.
    assign hv      = hx_reg ^ prod_reg[31:0];
    assign hmag    = hv[31] ? (32'd0 - hv) : hv;
    assign rem     = magx_reg - prod_reg[31:0];
    assign rem_fix = (rem >= HASH_SIZE32) ? (rem - HASH_SIZE32) : rem;

    // Distance test.
    assign dist_sum = dx2_reg + prod_reg;
    assign hit      = !dx2_reg[63] && !prod_reg[63] && (dist_sum < {1'b0, rsq_reg});

    assign live       = (bkt_epoch == epoch_reg) && bkt_hvalid;
    assign idx_ext    = 32'(idx_reg);
    assign idx_addr   = idx_ext[IW-1:0];
    assign idx_ok     = (idx_ext < MAXP32);
    assign count_full = (count_reg == CW'(MAX_NEIGHBORS));
    assign k_plus     = k_reg + CW'(1);
    assign hit_ext    = 32'(hits_rd);

    // Configuration and control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg  <= shns_pkg::ORIGIN_X_RST;
            origin_y_reg  <= shns_pkg::ORIGIN_Y_RST;
            inv_reg       <= shns_pkg::INV_SPACING_RST;
            rsq_reg       <= shns_pkg::RADIUS_SQ_RST;
            epoch_reg     <= '0;
            mode_reg      <= '0;
            nx_reg        <= '0;
            ny_reg        <= '0;
            cur_valid_reg <= 1'b0;
            steps_reg     <= '0;
            count_reg     <= '0;
            k_reg         <= '0;
            over_reg      <= 1'b0;
            clr_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    shns_pkg::CFG_ORIGIN_X:    origin_x_reg <= cfg_data[31:0];
                    shns_pkg::CFG_ORIGIN_Y:    origin_y_reg <= cfg_data[31:0];
                    shns_pkg::CFG_INV_SPACING: inv_reg      <= cfg_data[31:0];
                    shns_pkg::CFG_RADIUS_SQ:   rsq_reg      <= cfg_data;
                endcase
            end
            res_valid_reg <= (op == shns_pkg::OP_OUT) || (op == shns_pkg::OP_EMPTY);
            unique case (op)
                shns_pkg::OP_CLEAR: clr_reg <= clr_reg + HW'(1);
                shns_pkg::OP_EPOCH: epoch_reg <= epoch_reg + 32'd1;
                shns_pkg::OP_LOAD:
                begin
                    mode_reg  <= mode;
                    nx_reg    <= '0;
                    ny_reg    <= '0;
                    count_reg <= '0;
                    k_reg     <= '0;
                    over_reg  <= 1'b0;
                end
                shns_pkg::OP_BCHK:
                begin
                    cur_valid_reg <= live;
                    steps_reg     <= '0;
                end
                shns_pkg::OP_CMP:
                begin
                    if (hit)
                    begin
                        if (count_full)
                        begin
                            over_reg <= 1'b1;
                        end
                        else
                        begin
                            count_reg <= count_reg + CW'(1);
                        end
                    end
                    cur_valid_reg <= st_lvalid;
                    steps_reg     <= steps_reg + SW'(1);
                end
                shns_pkg::OP_NEXTC:
                begin
                    if (ny_reg == 2'd2)
                    begin
                        ny_reg <= '0;
                        nx_reg <= nx_reg + 2'd1;
                    end
                    else
                    begin
                        ny_reg <= ny_reg + 2'd1;
                    end
                end
                shns_pkg::OP_OUT: k_reg <= k_plus;
                default:
                begin
                    clr_reg <= clr_reg;
                end
            endcase
        end
    end

    // Payload registers of the arithmetic.
    always_ff @(posedge clk)
    begin
        unique case (op)
            shns_pkg::OP_LOAD:
            begin
                idx_reg <= particle_index;
                px_reg  <= pos_x;
                py_reg  <= pos_y;
            end
            shns_pkg::OP_GM:
            begin
                signx_reg <= org_dx[32];
                magx_reg  <= org_dx[31:0];
                signy_reg <= org_dy[32];
                magy_reg  <= org_dy[31:0];
            end
            shns_pkg::OP_GX, shns_pkg::OP_HX, shns_pkg::OP_RQ, shns_pkg::OP_RH,
            shns_pkg::OP_DX:
            begin
                prod_reg <= mul_p;
            end
            shns_pkg::OP_GY:
            begin
                gx_reg   <= cell_of(prod_reg, signx_reg);
                prod_reg <= mul_p;
            end
            shns_pkg::OP_GYC: gy_reg <= cell_of(prod_reg, signy_reg);
            shns_pkg::OP_CELL:
            begin
                if (mode_reg == shns_pkg::MODE_QUERY)
                begin
                    cx_reg <= gx_reg + {30'd0, nx_reg} - 32'd1;
                    cy_reg <= gy_reg + {30'd0, ny_reg} - 32'd1;
                end
                else
                begin
                    cx_reg <= gx_reg;
                    cy_reg <= gy_reg;
                end
            end
            shns_pkg::OP_HY:
            begin
                hx_reg   <= prod_reg[31:0];
                prod_reg <= mul_p;
            end
            shns_pkg::OP_HM: magx_reg <= hmag;
            shns_pkg::OP_RC: hash_reg <= rem_fix[HW-1:0];
            shns_pkg::OP_BCHK: cur_id_reg <= bkt_head;
            shns_pkg::OP_DM:
            begin
                magx_reg <= st_dx[31:0];
                magy_reg <= st_dy[31:0];
            end
            shns_pkg::OP_DY:
            begin
                dx2_reg  <= prod_reg;
                prod_reg <= mul_p;
            end
            shns_pkg::OP_CMP: cur_id_reg <= st_next;
            shns_pkg::OP_OUT:
            begin
                res_index_reg <= hit_ext[11:0];
                res_found_reg <= 1'b1;
                res_last_reg  <= (k_plus == count_reg);
                res_over_reg  <= over_reg;
            end
            shns_pkg::OP_EMPTY:
            begin
                res_index_reg <= '0;
                res_found_reg <= 1'b0;
                res_last_reg  <= 1'b1;
                res_over_reg  <= 1'b0;
            end
            default:
            begin
                hash_reg <= hash_reg;
            end
        endcase
    end

    // Bucket store: epoch mark, head valid and head index per bucket.
    assign bkt_we    = (op == shns_pkg::OP_CLEAR) || ((op == shns_pkg::OP_IWR) && idx_ok);
    assign bkt_waddr = (op == shns_pkg::OP_CLEAR) ? clr_reg : hash_reg;
    assign bkt_wdata = (op == shns_pkg::OP_CLEAR) ? '0 : {epoch_reg, 1'b1, idx_addr};
    assign bkt_re    = (op == shns_pkg::OP_BRD);

    shns_ram #(
        .WIDTH (BW),
        .DEPTH (HASH_SIZE)
    ) u_bucket_ram (
        .clk     (clk),
        .wr_en   (bkt_we),
        .wr_addr (bkt_waddr),
        .wr_data (bkt_wdata),
        .rd_en   (bkt_re),
        .rd_addr (hash_reg),
        .rd_data (bkt_rd)
    );

    // Particle store: position and list link per particle.
    assign part_we    = (op == shns_pkg::OP_IWR) && idx_ok;
    assign part_wdata = {px_reg, py_reg, live, bkt_head};
    assign part_re    = (op == shns_pkg::OP_PRD);

    shns_ram #(
        .WIDTH (PW),
        .DEPTH (MAX_PARTICLES)
    ) u_particle_ram (
        .clk     (clk),
        .wr_en   (part_we),
        .wr_addr (idx_addr),
        .wr_data (part_wdata),
        .rd_en   (part_re),
        .rd_addr (cur_id_reg),
        .rd_data (part_rd)
    );

    // Result buffer: neighbours are held until the walk knows about overflow.
    assign hits_we = (op == shns_pkg::OP_CMP) && hit && !count_full;
    assign hits_re = (op == shns_pkg::OP_ORD);

    shns_ram #(
        .WIDTH (IW),
        .DEPTH (MAX_NEIGHBORS)
    ) u_hits_ram (
        .clk     (clk),
        .wr_en   (hits_we),
        .wr_addr (count_reg[HAW-1:0]),
        .wr_data (cur_id_reg),
        .rd_en   (hits_re),
        .rd_addr (k_reg[HAW-1:0]),
        .rd_data (hits_rd)
    );

    // Status towards the controller.
    assign status.clr_done   = (clr_reg == HW'(HASH_SIZE - 1));
    assign status.query      = (mode_reg == shns_pkg::MODE_QUERY);
    assign status.walk_more  = cur_valid_reg && (steps_reg < SW'(MAX_PARTICLES));
    assign status.last_cell  = (nx_reg == 2'd2) && (ny_reg == 2'd2);
    assign status.count_zero = (count_reg == '0);
    assign status.out_last   = (k_plus == count_reg);

    assign result_valid   = res_valid_reg;
    assign neighbor_index = res_index_reg;
    assign found          = res_found_reg;
    assign last_result    = res_last_reg;
    assign overflow       = res_over_reg;

    // A result without a neighbour is the lone, final result of an empty query.
    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !found |-> last_result && !overflow)
        else $error("empty result not marked as final");

    // Dropped neighbours only once the buffer is full.
    a_over_full: assert property (@(posedge clk) disable iff (!rst_n)
        over_reg |-> count_full)
        else $error("overflow set before the buffer is full");

    // Buffered neighbours never exceed the cap.
    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_NEIGHBORS))
        else $error("neighbour count beyond cap");

    // Results are only issued after a read of the result buffer.
    a_out_after_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (op == shns_pkg::OP_OUT) |-> $past(op) == shns_pkg::OP_ORD)
        else $error("result issued without a buffer read");

endmodule
